// File: sv/mtcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcs_pkg
// Shared types and constants for the coil and discrete-input server.
// ----------------------------------------------------------------------------
package mtcs_pkg;

    // relay bank
    localparam int RELAY_COUNT = 4;
    localparam int RELAY_BITS  = 4;
    localparam logic [RELAY_BITS-1:0] RELAY_MASK =
        RELAY_BITS'(((1 << RELAY_COUNT) - 1) & ((1 << RELAY_BITS) - 1));

    // request header bytes that are ever looked at (0 through 13)
    localparam int HDR_BYTES = 14;
    localparam int CNT_W     = $clog2(HDR_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(HDR_BYTES);
    localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(6);

    // function codes
    localparam logic [7:0] FC_READ_COILS   = 8'h01;
    localparam logic [7:0] FC_READ_INPUTS  = 8'h02;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h05;
    localparam logic [7:0] FC_WRITE_MULTI  = 8'h0f;

    // header limits
    localparam logic [15:0] LEN_MAX   = 16'd8;
    localparam logic [15:0] ADDR_MAX  = 16'd3;
    localparam logic [15:0] COUNT_MAX = 16'd4;

    // reply sizes
    localparam int IDX_W = 4;
    localparam logic [IDX_W-1:0] READ_LAST  = IDX_W'(9);
    localparam logic [IDX_W-1:0] WRITE_LAST = IDX_W'(11);
    localparam logic [7:0] READ_REMAIN  = 8'd4;
    localparam logic [7:0] WRITE_REMAIN = 8'd6;
    localparam logic [7:0] READ_BYTES   = 8'd1;

    // command queue depth
    localparam int QUEUE_DEPTH = 2;

    // one classified request, ready to be carried out
    typedef struct packed {
        logic                  is_read;
        logic                  rd_coils;
        logic [7:0]            tid_hi;
        logic [7:0]            tid_lo;
        logic [7:0]            unit;
        logic [7:0]            fc;
        logic [7:0]            b8;
        logic [7:0]            b9;
        logic [7:0]            b10;
        logic [7:0]            b11;
        logic [RELAY_BITS-1:0] wmask;
        logic [RELAY_BITS-1:0] wdata;
    } mtcs_cmd_t;

endpackage

// File: sv/modbus_tcp_coil_server.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_tcp_coil_server
// Coil and discrete-input server: checks request frames, drives the relays
// and returns replies.
// ----------------------------------------------------------------------------
// Request bytes are taken one per cycle while in_stall is low. On the last
// byte of a frame the header is checked and a good request is queued; the
// queue holds two requests and in_stall rises only while both entries are
// occupied. The back end takes a queued request whenever it is idle,
// applies any relay write at once and then sends the reply at one byte per
// cycle while out_stall is low: 12 bytes for function 5 or 15, 10 bytes for
// function 1 or 2. Bad frames and unknown function codes are dropped
// silently. relay_outputs on every reply byte shows the relay state after
// the request that the reply answers.
module modbus_tcp_coil_server (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] frame_byte,
    input  logic       frame_end,
    input  logic [3:0] input_pins,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] reply_byte,
    output logic       reply_end,
    output logic [3:0] relay_outputs
);

    logic                push;
    logic                pop;
    logic                queue_full;
    logic                queue_empty;
    mtcs_pkg::mtcs_cmd_t push_cmd;
    mtcs_pkg::mtcs_cmd_t pop_cmd;

    mtcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .frame_byte (frame_byte),
        .frame_end  (frame_end),
        .input_pins (input_pins),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    mtcs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    mtcs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .queue_empty   (queue_empty),
        .pop_cmd       (pop_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .reply_byte    (reply_byte),
        .reply_end     (reply_end),
        .relay_outputs (relay_outputs)
    );

endmodule

// File: sv/mtcs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcs_front
// Collects request bytes, checks the header on the last byte and builds
// a command for the back end.
// ----------------------------------------------------------------------------
module mtcs_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            frame_byte,
    input  logic                  frame_end,
    input  logic [3:0]            input_pins,
    input  logic                  queue_full,
    output logic                  push,
    output mtcs_pkg::mtcs_cmd_t   push_cmd
);

    logic [7:0]                    hdr_reg [mtcs_pkg::HDR_BYTES];
    logic [mtcs_pkg::CNT_W-1:0]    count_reg;
    logic [mtcs_pkg::CNT_W-1:0]    count_next;
    logic [mtcs_pkg::CNT_W-1:0]    count_inc;
    logic [7:0]                    hv [mtcs_pkg::HDR_BYTES];
    logic                          accept;
    logic                          good;
    logic                          fc_known;
    logic [15:0]                   w2;
    logic [15:0]                   len;
    logic [15:0]                   addr;
    logic [15:0]                   val;
    logic [7:0]                    fc;
    logic [1:0]                    a_single;
    logic [1:0]                    a_multi;
    logic [2:0]                    v_multi;
    logic [mtcs_pkg::RELAY_BITS-1:0] m_multi;
    logic [mtcs_pkg::RELAY_BITS-1:0] d_multi;
    logic [2:0]                    j_off;
    mtcs_pkg::mtcs_cmd_t           cmd;

    assign in_stall = queue_full;
    assign accept   = in_valid && !in_stall;

    // header as seen with the current byte merged in
    always_comb
    begin
        for (int i = 0; i < mtcs_pkg::HDR_BYTES; i++)
        begin
            hv[i] = (count_reg == mtcs_pkg::CNT_W'(i)) ? frame_byte : hdr_reg[i];
        end
    end

    assign count_inc = (count_reg == mtcs_pkg::CNT_SAT) ? count_reg
                                                        : count_reg + 1'b1;
    assign count_next = frame_end ? '0 : count_inc;

    assign w2   = {hv[2], hv[3]};
    assign len  = {hv[4], hv[5]};
    assign fc   = hv[7];
    assign addr = {hv[8], hv[9]};
    assign val  = {hv[10], hv[11]};

    assign fc_known = (fc == mtcs_pkg::FC_READ_COILS) || (fc == mtcs_pkg::FC_READ_INPUTS)
                   || (fc == mtcs_pkg::FC_WRITE_SINGLE) || (fc == mtcs_pkg::FC_WRITE_MULTI);

    assign good = (count_inc >= mtcs_pkg::CNT_MIN) && (w2 == 16'd0)
               && (len <= mtcs_pkg::LEN_MAX)
               && ({1'b0, count_inc} >= (5'd6 + len[4:0])) && fc_known;

    assign a_single = addr[1:0];
    assign a_multi  = (addr > mtcs_pkg::ADDR_MAX) ? 2'd3 : addr[1:0];
    assign v_multi  = (val > mtcs_pkg::COUNT_MAX) ? 3'd4 : val[2:0];

    // multiple write: relay k takes data bit k - addr when inside the count
    always_comb
    begin
        m_multi = '0;
        d_multi = '0;
        j_off   = '0;
        for (int k = 0; k < mtcs_pkg::RELAY_BITS; k++)
        begin
            j_off = 3'(k) - {1'b0, a_multi};
            if ((3'(k) >= {1'b0, a_multi}) && (j_off < v_multi))
            begin
                m_multi[k] = 1'b1;
                d_multi[k] = hv[13][j_off[1:0]];
            end
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.tid_hi   = hv[0];
        cmd.tid_lo   = hv[1];
        cmd.unit     = hv[6];
        cmd.fc       = fc;
        unique case (fc)
            mtcs_pkg::FC_WRITE_SINGLE:
            begin
                cmd.b9    = {6'd0, a_single};
                cmd.b10   = hv[10];
                cmd.b11   = hv[11];
                cmd.wmask = (mtcs_pkg::RELAY_BITS'(1) << a_single) & mtcs_pkg::RELAY_MASK;
                cmd.wdata = (val != 16'd0) ? '1 : '0;
            end
            mtcs_pkg::FC_WRITE_MULTI:
            begin
                cmd.b9    = {6'd0, a_multi};
                cmd.b11   = {5'd0, v_multi};
                cmd.wmask = m_multi & mtcs_pkg::RELAY_MASK;
                cmd.wdata = d_multi;
            end
            mtcs_pkg::FC_READ_COILS:
            begin
                cmd.is_read  = 1'b1;
                cmd.rd_coils = 1'b1;
                cmd.b8       = mtcs_pkg::READ_BYTES;
            end
            mtcs_pkg::FC_READ_INPUTS:
            begin
                cmd.is_read = 1'b1;
                cmd.b8      = mtcs_pkg::READ_BYTES;
                cmd.b9      = {4'd0, input_pins};
            end
            default:
            begin
                cmd.b8 = '0;
            end
        endcase
    end

    assign push     = accept && frame_end && good;
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    // header store, no reset
    always_ff @(posedge clk)
    begin
        if (accept && (count_reg < mtcs_pkg::CNT_SAT))
        begin
            hdr_reg[count_reg] <= frame_byte;
        end
    end

endmodule

// File: sv/mtcs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcs_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module mtcs_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mtcs_pkg::mtcs_cmd_t push_cmd,
    input  logic                pop,
    output mtcs_pkg::mtcs_cmd_t pop_cmd,
    output logic                full,
    output logic                empty
);

    localparam int PTR_W = (mtcs_pkg::QUEUE_DEPTH > 1) ? $clog2(mtcs_pkg::QUEUE_DEPTH) : 1;
    localparam int LVL_W = $clog2(mtcs_pkg::QUEUE_DEPTH + 1);

    mtcs_pkg::mtcs_cmd_t entry_reg [mtcs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [LVL_W-1:0]    level_reg;
    logic                do_push;
    logic                do_pop;

    assign full    = (level_reg == LVL_W'(mtcs_pkg::QUEUE_DEPTH));
    assign empty   = (level_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(mtcs_pkg::QUEUE_DEPTH - 1))
                            ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(mtcs_pkg::QUEUE_DEPTH - 1))
                            ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                level_reg <= level_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: sv/mtcs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcs_back
// Carries out queued commands: updates the relays and sends the reply
// one byte per transfer.
// ----------------------------------------------------------------------------
module mtcs_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                queue_empty,
    input  mtcs_pkg::mtcs_cmd_t pop_cmd,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          reply_byte,
    output logic                reply_end,
    output logic [3:0]          relay_outputs
);

    mtcs_pkg::mtcs_cmd_t             cur_reg;
    logic                            busy_reg;
    logic [mtcs_pkg::IDX_W-1:0]      idx_reg;
    logic [mtcs_pkg::RELAY_BITS-1:0] coil_state_reg;
    logic [mtcs_pkg::RELAY_BITS-1:0] coil_state_next;
    logic                            out_valid_reg;
    logic [7:0]                      byte_reg;
    logic                            end_reg;
    logic [3:0]                      relay_out_reg;
    logic                            load;
    logic                            last;
    logic [7:0]                      byte_sel;

    assign load = !out_valid_reg || !out_stall;
    assign pop  = !busy_reg && !queue_empty;
    assign last = (idx_reg == (cur_reg.is_read ? mtcs_pkg::READ_LAST
                                               : mtcs_pkg::WRITE_LAST));
    assign coil_state_next = (coil_state_reg & ~pop_cmd.wmask)
                           | (pop_cmd.wdata & pop_cmd.wmask);

    always_comb
    begin
        case (idx_reg)
            4'd0:    byte_sel = cur_reg.tid_hi;
            4'd1:    byte_sel = cur_reg.tid_lo;
            4'd5:    byte_sel = cur_reg.is_read ? mtcs_pkg::READ_REMAIN
                                                : mtcs_pkg::WRITE_REMAIN;
            4'd6:    byte_sel = cur_reg.unit;
            4'd7:    byte_sel = cur_reg.fc;
            4'd8:    byte_sel = cur_reg.b8;
            4'd9:    byte_sel = cur_reg.rd_coils ? {4'd0, coil_state_reg} : cur_reg.b9;
            4'd10:   byte_sel = cur_reg.b10;
            4'd11:   byte_sel = cur_reg.b11;
            default: byte_sel = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            idx_reg        <= '0;
            coil_state_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg       <= 1'b1;
                idx_reg        <= '0;
                coil_state_reg <= coil_state_next;
            end
            else if (busy_reg && load)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (load)
            begin
                out_valid_reg <= busy_reg;
            end
        end
    end

    // command and reply payload, no reset
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= pop_cmd;
        end
        if (busy_reg && load)
        begin
            byte_reg      <= byte_sel;
            end_reg       <= last;
            relay_out_reg <= coil_state_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign reply_byte    = byte_reg;
    assign reply_end     = end_reg;
    assign relay_outputs = relay_out_reg;

endmodule

// File: sv/mtcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcs_checker
// Port-level checks on the reply channel of the coil server.
// ----------------------------------------------------------------------------
module mtcs_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] reply_byte,
    input  logic       reply_end,
    input  logic [3:0] relay_outputs
);

    // stalled reply byte holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(reply_byte)
                                   && $stable(reply_end))
    else $error("reply payload changed while stalled");

    // bytes of one reply follow back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !reply_end |=> out_valid)
    else $error("gap inside a reply");

    // relay state does not move in the middle of a reply
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reply_end |=> $stable(relay_outputs))
    else $error("relay state changed inside a reply");

endmodule

bind modbus_tcp_coil_server mtcs_checker u_mtcs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .reply_byte    (reply_byte),
    .reply_end     (reply_end),
    .relay_outputs (relay_outputs)
);
